### src/kruskal_mst_union_find_assert.svh
// assertion macros for the spanning tree block
// no dependencies; empty bodies under synthesis
`ifndef KRUSKAL_MST_UNION_FIND_ASSERT_SVH
`define KRUSKAL_MST_UNION_FIND_ASSERT_SVH
`ifndef SYNTHESIS
`define KMST_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMST_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KMST_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define KMST_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### src/kmst_pkg.sv
// types, constants and state codes for the spanning tree block
// no dependencies
package kmst_pkg;
    localparam int KMST_MAX_NODES   = 64;
    localparam int KMST_MAX_EDGES   = 256;
    localparam int KMST_WEIGHT_BITS = 32;
    localparam logic [6:0] KMST_NODE_COUNT_RESET = 7'd64;

    typedef struct packed {
        logic [5:0]  edge_node_a;
        logic [5:0]  edge_node_b;
        logic [31:0] edge_weight;
        logic        edge_present;
        logic        batch_last;
    } kmst_in_t;

    typedef struct packed {
        logic [5:0]  tree_node_a;
        logic [5:0]  tree_node_b;
        logic [31:0] tree_weight;
        logic        tree_valid;
        logic        tree_last;
        logic        tree_spanning;
        logic        store_overflow;
    } kmst_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PCLR,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FIND,
        ST_JOIN,
        ST_EMIT,
        ST_DONE
    } kmst_state_t;
endpackage

### src/kruskal_mst_union_find.sv
// channel   dir  payload     handshake
// edge in   in   kmst_in_t   in_valid / in_stall
// tree out  out  kmst_out_t  out_valid / out_stall
// cfg       in   7 bits      cfg_we
// loading: one cycle per edge beat, edges in arrival order in the store
// closing beat: parent clear pass over all MAX_NODES entries, then insertion sort of an index
// list kept in a second memory (O(E^2) worst), with edge weights read from the store port
// walk: per edge an index read, a store read, one parent lookup per hop and per root, a join
// ST_DONE and ST_EMIT close the run; parents undefined after reset until the clear pass
// out_stall holds a join or the closing beat
// depends on kmst_pkg, kmst_edge_mem and kruskal_mst_union_find_assert.svh
`include "kruskal_mst_union_find_assert.svh"
module kruskal_mst_union_find
    import kmst_pkg::*;
#(
    parameter int MAX_NODES   = KMST_MAX_NODES,
    parameter int MAX_EDGES   = KMST_MAX_EDGES,
    parameter int WEIGHT_BITS = KMST_WEIGHT_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [6:0] cfg_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  kmst_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output kmst_out_t out_data
);
    localparam int EB = $clog2(MAX_EDGES);
    localparam int NB = $clog2(MAX_NODES);
    localparam int CB = EB + 1;
    localparam int MW = 12 + WEIGHT_BITS;

    // sort keeps the index list in a second memory
    kmst_state_t state_reg, state_next;
    logic [6:0]  ncount_reg;
    logic [CB-1:0] count_reg, count_next;
    logic [CB-1:0] i_reg, i_next;
    logic [CB-1:0] j_reg, j_next;
    logic [5:0]  acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [NB-1:0] pclr_reg, pclr_next;
    logic [5:0]  parent_mem [MAX_NODES];
    logic [5:0]  p_rd;
    logic [NB-1:0] praddr;
    logic [5:0]  a_reg, a_next, b_reg, b_next, ra_reg, ra_next, rb_reg, rb_next;
    logic        fb_reg, fb_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next, curw_reg, curw_next;
    logic [EB-1:0] cur_reg, cur_next;
    logic [1:0]  ph_reg, ph_next;
    kmst_out_t   pend_reg, pend_next;
    logic        pend_v_reg, pend_v_next;
    kmst_out_t   out_reg, out_next;
    logic        outv_reg, outv_next;

    logic [6:0]  n_eff;
    logic [5:0]  need;
    logic        we;
    logic [EB-1:0] waddr, raddr;
    logic [MW-1:0] wdata, rdata;
    logic        owe;
    logic [EB-1:0] owaddr, oraddr, odata_w;
    logic [EB-1:0] ord_mem [MAX_EDGES];
    logic [EB-1:0] ord_rd;
    logic        pwe;
    logic [5:0]  pwaddr, pwdata;
    logic        out_free;

    assign n_eff = (ncount_reg == 7'd0) ? 7'd1 :
                   (ncount_reg > 7'(MAX_NODES)) ? 7'(MAX_NODES) : ncount_reg;
    assign need = 6'(n_eff - 7'd1);
    assign out_free = !outv_reg || !out_stall;

    kmst_edge_mem #(.DEPTH(MAX_EDGES), .WIDTH(MW)) u_mem
    (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (owe)
        begin
            ord_mem[owaddr] <= odata_w;
        end
        ord_rd <= ord_mem[oraddr];
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            parent_mem[pwaddr[NB-1:0]] <= pwdata;
        end
        p_rd <= parent_mem[praddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            ncount_reg <= KMST_NODE_COUNT_RESET;
            count_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            pclr_reg   <= '0;
            ph_reg     <= '0;
            fb_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_we)
            begin
                ncount_reg <= cfg_data;
            end
            count_reg  <= count_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            pclr_reg   <= pclr_next;
            ph_reg     <= ph_next;
            fb_reg     <= fb_next;
            pend_v_reg <= pend_v_next;
            outv_reg   <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        ra_reg   <= ra_next;
        rb_reg   <= rb_next;
        w_reg    <= w_next;
        curw_reg <= curw_next;
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        logic [5:0] x;
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        pclr_next   = pclr_reg;
        ph_next     = ph_reg;
        fb_next     = fb_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        w_next      = w_reg;
        curw_next   = curw_reg;
        cur_next    = cur_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        out_next    = out_reg;
        outv_next   = outv_reg;
        in_stall    = 1'b1;
        we          = 1'b0;
        waddr       = count_reg[EB-1:0];
        wdata       = {in_data.edge_node_a, in_data.edge_node_b,
                       in_data.edge_weight[WEIGHT_BITS-1:0]};
        raddr       = '0;
        owe         = 1'b0;
        owaddr      = '0;
        odata_w     = '0;
        oraddr      = '0;
        pwe         = 1'b0;
        pwaddr      = '0;
        pwdata      = '0;
        x           = fb_reg ? rb_reg : ra_reg;
        praddr      = x[NB-1:0];

        if (outv_reg && !out_stall)
        begin
            outv_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.edge_present)
                    begin
                        if (count_reg < CB'(MAX_EDGES))
                        begin
                            we = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (in_data.batch_last)
                    begin
                        state_next = ST_PCLR;
                        pclr_next  = '0;
                        i_next     = '0;
                    end
                end
            end
            ST_PCLR:
            begin
                pwe    = 1'b1;
                pwaddr = 6'(pclr_reg);
                pwdata = 6'(pclr_reg);
                pclr_next = pclr_reg + 1'b1;
                if (pclr_reg == NB'(MAX_NODES - 1))
                begin
                    state_next = ST_SORT_RD;
                    ph_next    = 2'd0;
                end
            end
            // insertion: ph 0 fetch weight of edge i, then shift down
            ST_SORT_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    state_next  = ST_WALK_RD;
                    i_next      = '0;
                    acc_next    = '0;
                    pend_v_next = 1'b0;
                    ph_next     = 2'd0;
                end
                else if (ph_reg == 2'd0)
                begin
                    raddr   = i_reg[EB-1:0];
                    ph_next = 2'd1;
                end
                else
                begin
                    curw_next = rdata[WEIGHT_BITS-1:0];
                    cur_next  = i_reg[EB-1:0];
                    j_next    = i_reg;
                    ph_next   = 2'd0;
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP:
            begin
                if (j_reg == '0)
                begin
                    state_next = ST_SORT_WR;
                end
                else if (ph_reg == 2'd0)
                begin
                    oraddr  = EB'(j_reg - 1'b1);
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    raddr   = ord_rd;
                    cur_next = cur_reg;
                    w_next  = '0;
                    ph_next = 2'd2;
                    a_next  = 6'(ord_rd);
                    // keep index of predecessor
                    rb_next = rb_reg;
                    owaddr  = '0;
                    oraddr  = EB'(j_reg - 1'b1);
                end
                else
                begin
                    oraddr = EB'(j_reg - 1'b1);
                    ph_next = 2'd0;
                    if (rdata[WEIGHT_BITS-1:0] > curw_reg)
                    begin
                        owe     = 1'b1;
                        owaddr  = j_reg[EB-1:0];
                        odata_w = ord_rd;
                        j_next  = j_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SORT_WR;
                    end
                end
            end
            ST_SORT_WR:
            begin
                owe        = 1'b1;
                owaddr     = j_reg[EB-1:0];
                odata_w    = cur_reg;
                i_next     = i_reg + 1'b1;
                ph_next    = 2'd0;
                state_next = ST_SORT_RD;
            end
            ST_WALK_RD:
            begin
                if (i_reg >= count_reg || acc_reg >= need)
                begin
                    state_next = ST_DONE;
                end
                else if (ph_reg == 2'd0)
                begin
                    oraddr  = i_reg[EB-1:0];
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    oraddr  = i_reg[EB-1:0];
                    raddr   = ord_rd;
                    ph_next = 2'd2;
                end
                else
                begin
                    a_next  = rdata[MW-1 -: 6];
                    b_next  = rdata[MW-7 -: 6];
                    w_next  = rdata[WEIGHT_BITS-1:0];
                    ra_next = rdata[MW-1 -: 6];
                    rb_next = rdata[MW-7 -: 6];
                    ph_next = 2'd0;
                    state_next = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK:
            begin
                i_next = i_reg + 1'b1;
                if (7'(a_reg) >= n_eff || 7'(b_reg) >= n_eff)
                begin
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    fb_next    = 1'b0;
                    ph_next    = 2'd0;
                    state_next = ST_FIND;
                end
            end
            // ph 0 looks up the parent of x, ph 1 compares
            ST_FIND:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    ph_next = 2'd0;
                    if (p_rd != x)
                    begin
                        if (fb_reg)
                        begin
                            rb_next = p_rd;
                        end
                        else
                        begin
                            ra_next = p_rd;
                        end
                    end
                    else if (!fb_reg)
                    begin
                        fb_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_JOIN;
                    end
                end
            end
            ST_JOIN:
            begin
                if (ra_reg == rb_reg)
                begin
                    state_next = ST_WALK_RD;
                end
                else if (!pend_v_reg || out_free)
                begin
                    pwe    = 1'b1;
                    pwaddr = ra_reg;
                    pwdata = rb_reg;
                    acc_next = acc_reg + 1'b1;
                    if (pend_v_reg)
                    begin
                        out_next  = pend_reg;
                        outv_next = 1'b1;
                    end
                    pend_next.tree_node_a    = a_reg;
                    pend_next.tree_node_b    = b_reg;
                    pend_next.tree_weight    = 32'(w_reg);
                    pend_next.tree_valid     = 1'b1;
                    pend_next.tree_last      = 1'b0;
                    pend_next.tree_spanning  = 1'b0;
                    pend_next.store_overflow = 1'b0;
                    pend_v_next = 1'b1;
                    state_next  = ST_WALK_RD;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '0;
                    end
                    out_next.tree_last      = 1'b1;
                    out_next.tree_spanning  = (acc_reg == need);
                    out_next.store_overflow = ovf_reg;
                    outv_next   = 1'b1;
                    pend_v_next = 1'b0;
                    count_next  = '0;
                    acc_next    = '0;
                    ovf_next    = 1'b0;
                    pclr_next   = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // parents are cleared after the closing beat of the next batch
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid = outv_reg;
    assign out_data  = out_reg;

    `KMST_ASSERT_NEVER(a_in_busy, clk, rst_n, (state_reg != ST_LOAD) && !in_stall, "input open while busy")
    `KMST_ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled beat changed")
    `KMST_ASSERT_NEVER(a_acc_over, clk, rst_n, acc_reg > need && state_reg != ST_LOAD, "too many tree edges")
endmodule

### src/kmst_edge_mem.sv
// edge store: one write port, one registered read port
// depends on kmst_pkg
module kmst_edge_mem
    import kmst_pkg::*;
#(
    parameter int DEPTH = KMST_MAX_EDGES,
    parameter int WIDTH = 44
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
